>>> rtl/modular_exponentiation_macros.svh
// assertion macros used by the checker of modular_exponentiation
// no dependencies
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// property checked at each rising clock edge outside reset
`define MEXP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at each rising clock edge, reset included
`define MEXP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/mexp_pkg.sv
// types and constants shared by the modular exponentiation block
// no dependencies
package mexp_pkg;

    localparam int OPERAND_WIDTH_DEF = 32;
    localparam int EXP_WIDTH_DEF     = 63;
    localparam int RESULT_W          = 64;
    localparam int MUL_W             = 32;

    typedef enum logic [1:0] {
        HALF_LL,
        HALF_LH,
        HALF_HL
    } t_mul_half;

    typedef enum logic [1:0] {
        PROD_HOLD,
        PROD_SET,
        PROD_ADDHI
    } t_prod_op;

    typedef struct packed {
        logic      load;
        logic      mul_en;
        logic      mul_src_acc;
        t_mul_half mul_half;
        t_prod_op  prod_op;
        logic      div_load;
        logic      div_from_base;
        logic      div_step;
        logic      wb_en;
        logic      wb_to_acc;
        logic      wb_from_rem;
        logic      exp_shift;
        logic      out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic exp_zero;
        logic exp_lsb;
        logic mod_zero;
        logic plain;
    } t_dp_status;

endpackage

>>> rtl/mexp_req_if.sv
// request channel: base, exponent and modulus with valid and ready
// depends on mexp_pkg
interface mexp_req_if
    import mexp_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF,
    parameter int EXP_WIDTH     = EXP_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic [OPERAND_WIDTH-1:0]     base;
    logic [EXP_WIDTH-1:0]         exponent;
    logic signed [OPERAND_WIDTH:0] modulus;

    modport source (output valid, output base, output exponent, output modulus, input ready);
    modport sink   (input valid, input base, input exponent, input modulus, output ready);
endinterface

>>> rtl/mexp_rsp_if.sv
// response channel: result and error flag with valid and ready
// depends on mexp_pkg
interface mexp_rsp_if
    import mexp_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [RESULT_W-1:0] result;
    logic                error;

    modport source (output valid, output result, output error, input ready);
    modport sink   (input valid, input result, input error, output ready);
endinterface

>>> rtl/modular_exponentiation.sv
// Modular exponentiation by right-to-left square-and-multiply, one request at a time.
// A request is taken only while the block is idle; a finished result waits in the
// output register while the next request is accepted. With a modulus of zero the
// block skips the exponent loop and returns the result with the error flag set.
// With modulus -1 each exponent bit up to the highest set one takes a squaring of
// the base, preceded by a multiply into the accumulator when the bit is set (64-bit
// wrapping products built from three partial products of the one 32x32 multiplier).
// Otherwise the base is first reduced, and each exponent bit takes one or two
// modular multiplies, each a low-half product followed by a pass of the restoring
// remainder unit, which retires two bits of the double-width dividend a cycle.
// depends on mexp_pkg, mexp_req_if, mexp_rsp_if, mexp_ctrl, mexp_dpath
module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF,
    parameter int EXP_WIDTH     = EXP_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mexp_req_if.sink     i_req,
    mexp_rsp_if.source   o_rsp
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    mexp_ctrl #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    mexp_dpath #(
        .OPERAND_WIDTH(OPERAND_WIDTH),
        .EXP_WIDTH    (EXP_WIDTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_cmd      (dp_cmd),
        .o_status   (dp_status),
        .i_base     (i_req.base),
        .i_exponent (i_req.exponent),
        .i_modulus  (i_req.modulus),
        .o_result   (o_rsp.result),
        .o_error    (o_rsp.error)
    );

endmodule

>>> rtl/mexp_dpath.sv
// datapath: operand registers, shared 32x32 multiplier, radix-4 remainder unit
// depends on mexp_pkg
module mexp_dpath
    import mexp_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF,
    parameter int EXP_WIDTH     = EXP_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  t_dp_cmd                       i_cmd,
    output t_dp_status                    o_status,
    input  logic [OPERAND_WIDTH-1:0]      i_base,
    input  logic [EXP_WIDTH-1:0]          i_exponent,
    input  logic signed [OPERAND_WIDTH:0] i_modulus,
    output logic [RESULT_W-1:0]           o_result,
    output logic                          o_error
);

    localparam int OW    = OPERAND_WIDTH;
    localparam int DVD_W = 2 * OPERAND_WIDTH;

    logic [RESULT_W-1:0]  r_acc;
    logic [RESULT_W-1:0]  r_base;
    logic [EXP_WIDTH-1:0] r_exp;
    logic [OW:0]          r_mag;
    logic                 r_mod_zero;
    logic                 r_plain;
    logic [RESULT_W-1:0]  r_pp;
    logic [RESULT_W-1:0]  r_prod;
    logic [DVD_W-1:0]     r_dvd;
    logic [OW:0]          r_rem;
    logic [RESULT_W-1:0]  r_result;
    logic                 r_error;

    logic [RESULT_W-1:0]  mul_a;
    logic [MUL_W-1:0]     op_x;
    logic [MUL_W-1:0]     op_y;
    logic [OW:0]          n_mag;
    logic [OW+1:0]        t1;
    logic [OW+1:0]        s1;
    logic [OW+1:0]        t2;
    logic [OW+1:0]        s2;
    logic [OW:0]          n_rem;
    logic [RESULT_W-1:0]  wb_val;

    // magnitude of the signed modulus, most negative value included
    assign n_mag = i_modulus[OW] ? (OW + 1)'(-i_modulus) : i_modulus;

    assign mul_a = i_cmd.mul_src_acc ? r_acc : r_base;

    always_comb begin
        case (i_cmd.mul_half)
            HALF_LH: begin
                op_x = mul_a[MUL_W-1:0];
                op_y = r_base[RESULT_W-1:MUL_W];
            end
            HALF_HL: begin
                op_x = mul_a[RESULT_W-1:MUL_W];
                op_y = r_base[MUL_W-1:0];
            end
            default: begin
                op_x = mul_a[MUL_W-1:0];
                op_y = r_base[MUL_W-1:0];
            end
        endcase
    end

    // two restoring steps per cycle
    always_comb begin
        t1    = {r_rem, r_dvd[DVD_W-1]};
        s1    = (t1 >= {1'b0, r_mag}) ? (t1 - {1'b0, r_mag}) : t1;
        t2    = {s1[OW:0], r_dvd[DVD_W-2]};
        s2    = (t2 >= {1'b0, r_mag}) ? (t2 - {1'b0, r_mag}) : t2;
        n_rem = s2[OW:0];
    end

    assign wb_val = i_cmd.wb_from_rem ? {{(RESULT_W - OW - 1){1'b0}}, n_rem} : r_prod;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_acc      <= RESULT_W'(1);
            r_base     <= {{(RESULT_W - OW){1'b0}}, i_base};
            r_exp      <= i_exponent;
            r_mag      <= n_mag;
            r_mod_zero <= (i_modulus == '0);
            r_plain    <= &i_modulus;
        end else if (i_cmd.wb_en) begin
            if (i_cmd.wb_to_acc) begin
                r_acc <= wb_val;
            end else begin
                r_base <= wb_val;
            end
        end

        if (i_cmd.exp_shift) begin
            r_exp <= r_exp >> 1;
        end

        if (i_cmd.mul_en) begin
            r_pp <= {{MUL_W{1'b0}}, op_x} * {{MUL_W{1'b0}}, op_y};
        end

        case (i_cmd.prod_op)
            PROD_SET:   r_prod <= r_pp;
            PROD_ADDHI: r_prod <= r_prod + {r_pp[MUL_W-1:0], {MUL_W{1'b0}}};
            default:    r_prod <= r_prod;
        endcase

        if (i_cmd.div_load) begin
            r_rem <= '0;
            if (i_cmd.div_from_base) begin
                r_dvd <= {{OW{1'b0}}, r_base[OW-1:0]};
            end else begin
                r_dvd <= r_pp[DVD_W-1:0];
            end
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_dvd <= r_dvd << 2;
        end

        if (i_cmd.out_load) begin
            r_result <= r_mod_zero ? '0 : r_acc;
            r_error  <= r_mod_zero;
        end
    end

    assign o_status.exp_zero = (r_exp == '0);
    assign o_status.exp_lsb  = r_exp[0];
    assign o_status.mod_zero = r_mod_zero;
    assign o_status.plain    = r_plain;

    assign o_result = r_result;
    assign o_error  = r_error;

endmodule

>>> rtl/mexp_ctrl.sv
// controller: sequences exponent bits, multiplies and remainder steps
// depends on mexp_pkg
module mexp_ctrl
    import mexp_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam int CNT_W = $clog2(OPERAND_WIDTH);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_REDUCE,
        ST_LOOP,
        ST_MUL_LL,
        ST_MUL_LH,
        ST_MUL_HL,
        ST_PADD,
        ST_WB,
        ST_DIV,
        ST_OUT
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_tgt_acc;
    logic             n_tgt_acc;
    logic             r_reduce;
    logic             n_reduce;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             mult_done;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_tgt_acc   = r_tgt_acc;
        n_reduce    = r_reduce;
        n_out_valid = r_out_valid && !i_out_ready;
        mult_done   = 1'b0;
        o_cmd       = '0;
        o_cmd.mul_src_acc = r_tgt_acc;
        o_cmd.wb_to_acc   = r_tgt_acc;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_status.mod_zero) begin
                    n_state = ST_OUT;
                end else if (i_status.plain) begin
                    n_state = ST_LOOP;
                end else begin
                    n_tgt_acc = 1'b0;
                    n_reduce  = 1'b1;
                    n_state   = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                o_cmd.div_load      = 1'b1;
                o_cmd.div_from_base = 1'b1;
                n_cnt               = CNT_W'(OPERAND_WIDTH - 1);
                n_state             = ST_DIV;
            end
            ST_LOOP: begin
                if (i_status.exp_zero) begin
                    n_state = ST_OUT;
                end else begin
                    n_tgt_acc = i_status.exp_lsb;
                    n_state   = ST_MUL_LL;
                end
            end
            ST_MUL_LL: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_half = HALF_LL;
                n_state        = ST_MUL_LH;
            end
            ST_MUL_LH: begin
                if (i_status.plain) begin
                    o_cmd.prod_op  = PROD_SET;
                    o_cmd.mul_en   = 1'b1;
                    o_cmd.mul_half = HALF_LH;
                    n_state        = ST_MUL_HL;
                end else begin
                    o_cmd.div_load = 1'b1;
                    n_cnt          = CNT_W'(OPERAND_WIDTH - 1);
                    n_state        = ST_DIV;
                end
            end
            ST_MUL_HL: begin
                o_cmd.prod_op  = PROD_ADDHI;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_half = HALF_HL;
                n_state        = ST_PADD;
            end
            ST_PADD: begin
                o_cmd.prod_op = PROD_ADDHI;
                n_state       = ST_WB;
            end
            ST_WB: begin
                o_cmd.wb_en = 1'b1;
                mult_done   = 1'b1;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    o_cmd.wb_en       = 1'b1;
                    o_cmd.wb_from_rem = 1'b1;
                    mult_done         = 1'b1;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // after a write-back: reduction ends, else square or go to the next bit
        if (mult_done) begin
            if (r_reduce) begin
                n_reduce = 1'b0;
                n_state  = ST_LOOP;
            end else if (r_tgt_acc) begin
                n_tgt_acc = 1'b0;
                n_state   = ST_MUL_LL;
            end else begin
                o_cmd.exp_shift = 1'b1;
                n_state         = ST_LOOP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_tgt_acc   <= 1'b0;
            r_reduce    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_tgt_acc   <= n_tgt_acc;
            r_reduce    <= n_reduce;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/mexp_checker.sv
// port-level checks for modular_exponentiation, bound to the top level
// depends on mexp_pkg and modular_exponentiation_macros.svh
`include "modular_exponentiation_macros.svh"

module mexp_checker
    import mexp_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [RESULT_W-1:0] i_result,
    input logic                i_error
);

    `MEXP_ASSERT(a_err_zero, i_clk, i_rst_n, i_out_valid && i_error |-> i_result == '0, "error item with nonzero result")
    `MEXP_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !i_in_ready, "request taken while busy")
    `MEXP_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_result) && $stable(i_error), "stalled item changed")
    `MEXP_ASSERT_ALWAYS(a_rst_out, i_clk, !i_rst_n |=> !i_out_valid, "item shown after reset")

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_result    (o_rsp.result),
    .i_error     (o_rsp.error)
);
